### sv/rbs_pkg.sv
// Shared constants and types for the ray versus box slab test.
`default_nettype none
package rbs_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int AXES           = 3;

  // per-axis flags that ride alongside the divider stages
  typedef struct packed {
    logic neg_hi;   // quotient toward the upper plane (center + half) is negative
    logic neg_lo;   // quotient toward the lower plane (center - half) is negative
    logic dzero;    // direction component is zero
    logic in_slab;  // origin lies within the slab, bounds included
  } rbs_axis_flags_t;

endpackage
`default_nettype wire

### sv/rbs_if.sv
// Request and result channel interfaces.
`default_nettype none
interface rbs_req_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_center_x;
  logic signed [COORD_BITS-1:0] box_center_y;
  logic signed [COORD_BITS-1:0] box_center_z;
  logic        [COORD_BITS-2:0] box_half_x;
  logic        [COORD_BITS-2:0] box_half_y;
  logic        [COORD_BITS-2:0] box_half_z;
  logic signed [COORD_BITS-1:0] ray_origin_x;
  logic signed [COORD_BITS-1:0] ray_origin_y;
  logic signed [COORD_BITS-1:0] ray_origin_z;
  logic signed [COORD_BITS-1:0] ray_dir_x;
  logic signed [COORD_BITS-1:0] ray_dir_y;
  logic signed [COORD_BITS-1:0] ray_dir_z;

  modport source (output valid, box_center_x, box_center_y, box_center_z,
                  box_half_x, box_half_y, box_half_z, ray_origin_x, ray_origin_y,
                  ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z, input ready);
  modport sink (input valid, box_center_x, box_center_y, box_center_z,
                box_half_x, box_half_y, box_half_z, ray_origin_x, ray_origin_y,
                ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z, output ready);
endinterface

interface rbs_rsp_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] hit_param;

  modport source (output valid, hit, hit_param, input ready);
  modport sink (input valid, hit, hit_param, output ready);
endinterface
`default_nettype wire

### sv/rbs_prep.sv
// Slab planes, crossing numerators and operand magnitudes for one axis.
`default_nettype none
module rbs_prep #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int MAG_W = COORD_BITS + 1,
  localparam int DVD_W = MAG_W + FRAC_BITS
) (
  input  wire logic signed [COORD_BITS-1:0] center,
  input  wire logic        [COORD_BITS-2:0] half,
  input  wire logic signed [COORD_BITS-1:0] origin,
  input  wire logic signed [COORD_BITS-1:0] dir,
  output      logic        [DVD_W-1:0]      dvd_hi,
  output      logic        [DVD_W-1:0]      dvd_lo,
  output      logic        [COORD_BITS-1:0] dsr,
  output      rbs_pkg::rbs_axis_flags_t     flags
);
  import rbs_pkg::*;

  logic signed [COORD_BITS+1:0] ce, he, oe, lo, hi, nhi, nlo, ahi, alo;
  logic signed [COORD_BITS:0]   de, ad;

  always_comb begin
    ce  = {{2{center[COORD_BITS-1]}}, center};
    oe  = {{2{origin[COORD_BITS-1]}}, origin};
    he  = $signed({3'b000, half});
    lo  = ce - he;
    hi  = ce + he;
    nhi = hi - oe;
    nlo = lo - oe;
    ahi = nhi[COORD_BITS+1] ? -nhi : nhi;
    alo = nlo[COORD_BITS+1] ? -nlo : nlo;
    de  = {dir[COORD_BITS-1], dir};
    ad  = dir[COORD_BITS-1] ? -de : de;
    dvd_hi = {ahi[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    dvd_lo = {alo[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    dsr    = ad[COORD_BITS-1:0];
    flags.neg_hi  = nhi[COORD_BITS+1] ^ dir[COORD_BITS-1];
    flags.neg_lo  = nlo[COORD_BITS+1] ^ dir[COORD_BITS-1];
    flags.dzero   = (dir == '0);
    flags.in_slab = (oe >= lo) && (oe <= hi);
  end
endmodule
`default_nettype wire

### sv/rbs_div.sv
// Unsigned restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module rbs_div #(
  parameter int DVD_W = 49,
  parameter int DSR_W = 32
) (
  input  wire logic             clk,
  input  wire logic [DVD_W-1:0] en,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DSR_W-1:0] dsr,
  output      logic [DVD_W-1:0] quo
);
  import rbs_pkg::*;

  logic [DSR_W-1:0] rem [DVD_W];
  logic [DVD_W-1:0] dv  [DVD_W];
  logic [DSR_W-1:0] ds  [DVD_W];
  logic [DVD_W-1:0] q   [DVD_W];

  logic [DSR_W-1:0] rem_next [DVD_W];
  logic [DVD_W-1:0] dv_next  [DVD_W];
  logic [DSR_W-1:0] ds_next  [DVD_W];
  logic [DVD_W-1:0] q_next   [DVD_W];

  always_comb begin
    for (int j = 0; j < DVD_W; j++) begin
      logic [DSR_W-1:0] pr;
      logic [DVD_W-1:0] pd, pq;
      logic [DSR_W-1:0] ps;
      logic [DSR_W:0]   trial, diff;
      logic             ge;
      pr = (j == 0) ? '0  : rem[(j == 0) ? 0 : j-1];
      pd = (j == 0) ? dvd : dv[(j == 0) ? 0 : j-1];
      ps = (j == 0) ? dsr : ds[(j == 0) ? 0 : j-1];
      pq = (j == 0) ? '0  : q[(j == 0) ? 0 : j-1];
      trial = {pr, pd[DVD_W-1]};
      diff  = trial - {1'b0, ps};
      ge    = (trial >= {1'b0, ps});
      rem_next[j] = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dv_next[j]  = {pd[DVD_W-2:0], 1'b0};
      ds_next[j]  = ps;
      q_next[j]   = {pq[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DVD_W; j++) begin
      if (en[j]) begin
        rem[j] <= rem_next[j];
        dv[j]  <= dv_next[j];
        ds[j]  <= ds_next[j];
        q[j]   <= q_next[j];
      end
    end
  end

  assign quo = q[DVD_W-1];
endmodule
`default_nettype wire

### sv/ray_box_slab_intersect.sv
// Top level: pipelined ray versus axis-aligned box slab test.
`default_nettype none
// Accepts one request per cycle while the pipeline is not backed up from the
// result side, and returns one result per request, in order. The stages are one
// prep stage, one stage per quotient bit of the six parallel restoring dividers,
// then tmin/tmax, entry/exit and the output register. Each stage holds on its
// own when the next is full, so bubbles close up under backpressure. A zero
// direction component bounds nothing when the origin is in that slab and
// misses otherwise; a miss returns hit_param = 0.
module ray_box_slab_intersect #(
  parameter int COORD_BITS = rbs_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rbs_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rbs_req_if.sink  req,
  rbs_rsp_if.source rsp
);
  import rbs_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;
  localparam int DVD_W = MAG_W + FRAC_BITS;
  localparam int T_W   = DVD_W + 2;
  localparam int S     = DVD_W + 4;
  localparam logic signed [T_W-1:0] POS_INF = T_W'(1) << DVD_W;
  localparam logic signed [T_W-1:0] NEG_INF = -POS_INF;
  localparam logic signed [T_W-1:0] SAT_HI  = T_W'((64'd1 << (COORD_BITS-1)) - 64'd1);
  localparam logic signed [T_W-1:0] SAT_LO  = -SAT_HI - T_W'(1);

  logic [S-1:0] v, en;

  always_comb begin
    en[S-1] = !v[S-1] || rsp.ready;
    for (int k = S-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < S; k++) begin
        if (en[k]) v[k] <= (k == 0) ? req.valid : v[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign req.ready = en[0];

  // prep stage
  logic signed [COORD_BITS-1:0] c_in [AXES], o_in [AXES], d_in [AXES];
  logic        [COORD_BITS-2:0] h_in [AXES];
  logic [DVD_W-1:0]      phi [AXES], plo [AXES];
  logic [COORD_BITS-1:0] pds [AXES];
  rbs_axis_flags_t       pfl [AXES];

  assign c_in[0] = req.box_center_x;
  assign c_in[1] = req.box_center_y;
  assign c_in[2] = req.box_center_z;
  assign h_in[0] = req.box_half_x;
  assign h_in[1] = req.box_half_y;
  assign h_in[2] = req.box_half_z;
  assign o_in[0] = req.ray_origin_x;
  assign o_in[1] = req.ray_origin_y;
  assign o_in[2] = req.ray_origin_z;
  assign d_in[0] = req.ray_dir_x;
  assign d_in[1] = req.ray_dir_y;
  assign d_in[2] = req.ray_dir_z;

  logic [DVD_W-1:0]      dvd_hi [AXES], dvd_lo [AXES];
  logic [COORD_BITS-1:0] dsr    [AXES];
  rbs_axis_flags_t       fl     [DVD_W+1][AXES];
  logic [DVD_W-1:0]      q_hi   [AXES], q_lo [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbs_prep #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_prep (
      .center(c_in[a]), .half(h_in[a]), .origin(o_in[a]), .dir(d_in[a]),
      .dvd_hi(phi[a]), .dvd_lo(plo[a]), .dsr(pds[a]), .flags(pfl[a])
    );
    rbs_div #(.DVD_W(DVD_W), .DSR_W(COORD_BITS)) u_div_hi (
      .clk(clk), .en(en[DVD_W:1]), .dvd(dvd_hi[a]), .dsr(dsr[a]), .quo(q_hi[a])
    );
    rbs_div #(.DVD_W(DVD_W), .DSR_W(COORD_BITS)) u_div_lo (
      .clk(clk), .en(en[DVD_W:1]), .dvd(dvd_lo[a]), .dsr(dsr[a]), .quo(q_lo[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < AXES; a++) begin
        dvd_hi[a] <= phi[a];
        dvd_lo[a] <= plo[a];
        dsr[a]    <= pds[a];
        fl[0][a]  <= pfl[a];
      end
    end
    for (int k = 1; k <= DVD_W; k++) begin
      if (en[k]) fl[k] <= fl[k-1];
    end
  end

  // per-axis ordering
  logic signed [T_W-1:0] tmin [AXES], tmax [AXES];
  logic signed [T_W-1:0] tmin_next [AXES], tmax_next [AXES];
  logic                  miss, miss_next;

  always_comb begin
    miss_next = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      logic signed [T_W-1:0] ta, tb;
      ta = $signed({2'b00, q_hi[a]});
      tb = $signed({2'b00, q_lo[a]});
      if (fl[DVD_W][a].neg_hi) ta = -ta;
      if (fl[DVD_W][a].neg_lo) tb = -tb;
      if (fl[DVD_W][a].dzero) begin
        tmin_next[a] = NEG_INF;
        tmax_next[a] = POS_INF;
        if (!fl[DVD_W][a].in_slab) miss_next = 1'b1;
      end else begin
        tmin_next[a] = (ta < tb) ? ta : tb;
        tmax_next[a] = (ta < tb) ? tb : ta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DVD_W+1]) begin
      tmin <= tmin_next;
      tmax <= tmax_next;
      miss <= miss_next;
    end
  end

  // entry and exit
  logic signed [T_W-1:0] entry, exit_t, entry_next, exit_next;
  logic                  ok;

  always_comb begin
    entry_next = tmin[0];
    exit_next  = tmax[0];
    for (int a = 1; a < AXES; a++) begin
      if (tmin[a] > entry_next) entry_next = tmin[a];
      if (tmax[a] < exit_next)  exit_next  = tmax[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DVD_W+2]) begin
      entry  <= entry_next;
      exit_t <= exit_next;
      ok     <= !miss;
    end
  end

  // output register
  logic                         hit_next;
  logic signed [COORD_BITS-1:0] param_next;

  always_comb begin
    hit_next = ok && (entry < exit_t);
    if (!hit_next)          param_next = '0;
    else if (entry > SAT_HI) param_next = SAT_HI[COORD_BITS-1:0];
    else if (entry < SAT_LO) param_next = SAT_LO[COORD_BITS-1:0];
    else                    param_next = entry[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[S-1]) begin
      rsp.hit       <= hit_next;
      rsp.hit_param <= param_next;
    end
  end

  assign rsp.valid = v[S-1];

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.hit_param == '0)
    else $error("miss result carries a nonzero parameter");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("pending result dropped");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    v == '0 |-> req.ready)
    else $error("empty pipeline refuses requests");
endmodule
`default_nettype wire

### tb/rbs_checker.sv
// Checker: predicts each slab test result and compares it with the block output.
`timescale 1ns / 1ps
`default_nettype none
module rbs_checker (
  input wire logic clk,
  input wire logic rst,
  rbs_req_if.sink  req,
  rbs_rsp_if.sink  rsp,
  output int       errors,
  output int       pending
);

  typedef struct packed {
    logic        hit;
    logic [31:0] param;
  } slab_result_t;

  slab_result_t expected_q[$];

  localparam longint T_NEG = -(64'sd1 <<< 62);
  localparam longint T_POS = (64'sd1 <<< 62);

  // narrows the [entry, exit] window by one axis, clears ok on a miss
  function automatic void narrow_axis(input logic signed [31:0] c, input logic [30:0] h,
                             input logic signed [31:0] o, input logic signed [31:0] d,
                             inout longint entry, inout longint exit_t, inout bit ok);
    longint lo, hi, ta, tb, tmin, tmax;
    lo = longint'(c) - longint'({1'b0, h});
    hi = longint'(c) + longint'({1'b0, h});
    if (d == 0) begin
      if (!(longint'(o) >= lo && longint'(o) <= hi)) ok = 0;
    end else begin
      ta = ((hi - longint'(o)) * 65536) / longint'(d);
      tb = ((lo - longint'(o)) * 65536) / longint'(d);
      tmin = (ta < tb) ? ta : tb;
      tmax = (ta < tb) ? tb : ta;
      if (tmin > entry) entry = tmin;
      if (tmax < exit_t) exit_t = tmax;
    end
  endfunction

  function automatic slab_result_t predict_slab_hit();
    longint entry, exit_t, sat;
    bit ok;
    slab_result_t r;
    entry = T_NEG;
    exit_t = T_POS;
    ok = 1;
    narrow_axis(req.box_center_x, req.box_half_x, req.ray_origin_x, req.ray_dir_x,
                entry, exit_t, ok);
    narrow_axis(req.box_center_y, req.box_half_y, req.ray_origin_y, req.ray_dir_y,
                entry, exit_t, ok);
    narrow_axis(req.box_center_z, req.box_half_z, req.ray_origin_z, req.ray_dir_z,
                entry, exit_t, ok);
    if (ok && entry < exit_t) begin
      sat = entry;
      if (sat > 64'sd2147483647) sat = 64'sd2147483647;
      if (sat < -64'sd2147483648) sat = -64'sd2147483648;
      r.hit = 1'b1;
      r.param = sat[31:0];
    end else begin
      r = '0;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    slab_result_t w;
    if (rst) begin
      errors <= errors;
    end else begin
      if (req.valid && req.ready) expected_q.push_back(predict_slab_hit());
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result at %0t", $time);
          errors++;
        end else begin
          w = expected_q.pop_front();
          if (rsp.hit !== w.hit) report("hit", 32'(rsp.hit), 32'(w.hit));
          if (rsp.hit_param !== w.param) report("hit_param", rsp.hit_param, w.param);
        end
      end
    end
    pending = expected_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench top: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int LATENCY = 54;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, cycles;
  bit   hold_rsp = 0;

  rbs_req_if req ();
  rbs_rsp_if rsp ();

  ray_box_slab_intersect u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  rbs_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                     .errors(errors), .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 0;
    req.box_center_x = 0; req.box_center_y = 0; req.box_center_z = 0;
    req.box_half_x = 0; req.box_half_y = 0; req.box_half_z = 0;
    req.ray_origin_x = 0; req.ray_origin_y = 0; req.ray_origin_z = 0;
    req.ray_dir_x = 0; req.ray_dir_y = 0; req.ray_dir_z = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end
  initial cycles = 0;

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rsp = 0;
      end
      g = (cycles % 4000 < 1000) ? 0 : gap_len();
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 20 * 65536)) - 10 * 65536);
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rnd_dir();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'(int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
      4: return {{31{1'b0}}, 1'b1};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rnd_half();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(0, 8 * 65536));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic send(input logic [31:0] c[3], input logic [30:0] h[3],
                      input logic [31:0] o[3], input logic [31:0] d[3]);
    req.valid <= 1'b1;
    req.box_center_x <= c[0]; req.box_center_y <= c[1]; req.box_center_z <= c[2];
    req.box_half_x <= h[0]; req.box_half_y <= h[1]; req.box_half_z <= h[2];
    req.ray_origin_x <= o[0]; req.ray_origin_y <= o[1]; req.ray_origin_z <= o[2];
    req.ray_dir_x <= d[0]; req.ray_dir_y <= d[1]; req.ray_dir_z <= d[2];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] c[3], o[3], d[3];
    logic [30:0] h[3];
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit box at origin
    c = '{0, 0, 0}; h = '{65536, 65536, 65536};
    o = '{-5 * 65536, 0, 0}; d = '{65536, 0, 0};
    send(c, h, o, d);                       // plain hit from outside
    o = '{0, 0, 0}; send(c, h, o, d);       // origin inside, negative entry
    d = '{0, 0, 0}; send(c, h, o, d);       // no constraining axis
    o = '{65536, 65536, -65536}; send(c, h, o, d); // zero dir, on the bounds
    o = '{65537, 0, 0}; send(c, h, o, d);   // zero dir, outside slab
    o = '{-5 * 65536, 65536, 0}; d = '{65536, 65536, 0};
    send(c, h, o, d);                       // touching an edge
    o = '{-5 * 65536, 0, 0}; d = '{-65536, 0, 0};
    send(c, h, o, d);                       // box behind the ray
    h = '{0, 0, 0}; o = '{-65536, 0, 0}; d = '{65536, 0, 0};
    send(c, h, o, d);                       // degenerate box
    c = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    h = '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff};
    o = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    d = '{1, -1, 1};
    send(c, h, o, d);                       // huge quotients, saturation
    d = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send(c, h, o, d);
    c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    d = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send(c, h, o, d);
    c = '{-1, -1, -1}; h = '{1, 1, 1}; o = '{0, 0, 0}; d = '{0, 0, 0};
    send(c, h, o, d);

    // let the pipeline drain completely
    idle(1);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 600; i++) begin
      if (i == 200) hold_rsp = 1;           // keeps feeding while results stall
      for (int a = 0; a < 3; a++) begin
        c[a] = rnd_coord(); h[a] = rnd_half(); d[a] = rnd_dir();
        // mostly rays aimed near the box so hits are common
        if ($urandom_range(0, 2) != 0)
          o[a] = c[a] + 32'(int'($urandom_range(0, 16 * 65536)) - 8 * 65536);
        else
          o[a] = rnd_coord();
      end
      send(c, h, o, d);
      if (i == 400) begin
        idle(1);
        while (pending != 0) @(posedge clk);
      end
      idle((i % 150 < 40) ? 0 : gap_len());
    end
    req.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
